>>> src/json_string_unescape_top_macros.svh
// Assertion macros used by the unescaper checker
`ifndef JSON_STRING_UNESCAPE_TOP_MACROS_SVH
`define JSON_STRING_UNESCAPE_TOP_MACROS_SVH

// Check a property outside reset
`define JSU_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check a property on every edge, reset included
`define JSU_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/jsu_pkg.sv
// Types, constants and helper functions for the JSON string unescaper
package jsu_pkg;

	typedef logic [7:0] byte_t;

	localparam logic [1:0] MODE_NORMAL = 2'd0;
	localparam logic [1:0] MODE_BSLASH = 2'd1;
	localparam logic [1:0] MODE_UHEX   = 2'd2;

	localparam byte_t CH_BSLASH = 8'h5C;
	localparam byte_t CH_U      = 8'h75;
	localparam byte_t CH_N      = 8'h6E;
	localparam byte_t CH_R      = 8'h72;
	localparam byte_t CH_T      = 8'h74;
	localparam byte_t CH_LF     = 8'h0A;
	localparam byte_t CH_CR     = 8'h0D;
	localparam byte_t CH_TAB    = 8'h09;

	localparam logic [15:0] CP_ONE_LIMIT = 16'h0080;
	localparam logic [15:0] CP_TWO_LIMIT = 16'h0800;
	localparam byte_t LEAD_TWO  = 8'hC0;
	localparam byte_t LEAD_THREE = 8'hE0;
	localparam byte_t CONT_MARK = 8'h80;

	typedef struct packed {
		logic       ok;
		logic [3:0] digit;
	} hex_t;

	function automatic byte_t map_escape(input byte_t c);
		byte_t r;
		case (c)
			CH_N:    r = CH_LF;
			CH_R:    r = CH_CR;
			CH_T:    r = CH_TAB;
			default: r = c;
		endcase
		return r;
	endfunction

	function automatic hex_t hex_digit(input byte_t c);
		hex_t h;
		h.ok    = 1'b1;
		h.digit = 4'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			h.digit = 4'(c - 8'h30);
		end else if (c >= 8'h61 && c <= 8'h66) begin
			h.digit = 4'(c - 8'h57);
		end else if (c >= 8'h41 && c <= 8'h46) begin
			h.digit = 4'(c - 8'h37);
		end else begin
			h.ok = 1'b0;
		end
		return h;
	endfunction

endpackage

>>> src/json_string_unescape_top.sv
// JSON string unescaper: raw string body bytes in, UTF-8 bytes out
//
// Input channel: in_byte/in_last with in_valid and in_stall. One raw byte of
// the string body per transaction; in_last marks the final byte.
// Output channel: out_byte/byte_valid/end_mark with out_valid and out_stall.
// Each input byte yields zero to three output bytes. A final byte that yields
// no data gives one transaction with byte_valid low and end_mark high.
// end_mark is high on the last transaction caused by a final input byte.
// The first result reaches the output in the cycle after its byte is taken.
// Throughput: one input byte per cycle while each byte yields at most one
// result and out_stall is low; a byte that yields more results holds the
// input while the single three-entry result buffer drains one byte a cycle.
// When out_stall is high the buffered result holds, and once the buffer holds
// more than one entry, or one entry that is stalled, in_stall rises.
// Reset clears the escape state and empties the result buffer; the next byte
// starts a new string. State also returns to that point after each final byte.
module json_string_unescape_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  jsu_pkg::byte_t in_byte,
	input  logic          in_last,
	output logic          out_valid,
	input  logic          out_stall,
	output jsu_pkg::byte_t out_byte,
	output logic          byte_valid,
	output logic          end_mark
);
	import jsu_pkg::*;

	logic [1:0]  mode_q, mode_d;
	logic [1:0]  hcnt_q, hcnt_d;
	logic [15:0] hval_q, hval_d;
	logic        hstop_q, hstop_d;
	byte_t       held_q [3];
	logic        held_we;

	byte_t       obuf_q [3];
	logic [1:0]  ocnt_q;
	logic        olast_q;
	logic        obv_q;

	byte_t       r [3];
	logic [1:0]  rn;
	logic        rbv;
	byte_t       rb [3];
	logic [1:0]  rk;
	logic [15:0] cp;
	hex_t        hx;

	logic        in_acc;
	logic        out_acc;

	assign out_valid  = (ocnt_q != 2'd0);
	assign in_stall   = (ocnt_q > 2'd1) || ((ocnt_q == 2'd1) && out_stall);
	assign in_acc     = in_valid && !in_stall;
	assign out_acc    = out_valid && !out_stall;
	assign out_byte   = obuf_q[0];
	assign byte_valid = obv_q;
	assign end_mark   = olast_q && (ocnt_q == 2'd1);

	always_comb begin
		r[0]    = '0;
		r[1]    = '0;
		r[2]    = '0;
		rn      = 2'd0;
		rbv     = 1'b1;
		mode_d  = mode_q;
		hcnt_d  = hcnt_q;
		hval_d  = hval_q;
		hstop_d = hstop_q;
		held_we = 1'b0;
		hx      = hex_digit(in_byte);
		rk      = hcnt_q + 2'd1;
		cp      = hval_q;
		for (int j = 0; j < 3; j++) begin
			rb[j] = (2'(j) < hcnt_q) ? held_q[j] : in_byte;
		end
		case (mode_q)
			MODE_BSLASH: begin
				if (in_byte == CH_U) begin
					mode_d  = MODE_UHEX;
					hcnt_d  = 2'd0;
					hval_d  = '0;
					hstop_d = 1'b0;
				end else begin
					r[rn] = map_escape(in_byte);
					rn = rn + 2'd1;
					mode_d = MODE_NORMAL;
				end
			end
			MODE_UHEX: begin
				if (hcnt_q == 2'd3) begin
					if (!hstop_q && hx.ok) begin
						cp = {hval_q[11:0], hx.digit};
					end
					if (cp < CP_ONE_LIMIT) begin
						r[0] = cp[7:0];
						rn = 2'd1;
					end else if (cp < CP_TWO_LIMIT) begin
						r[0] = LEAD_TWO | {3'b000, cp[10:6]};
						r[1] = CONT_MARK | {2'b00, cp[5:0]};
						rn = 2'd2;
					end else begin
						r[0] = LEAD_THREE | {4'b0000, cp[15:12]};
						r[1] = CONT_MARK | {2'b00, cp[11:6]};
						r[2] = CONT_MARK | {2'b00, cp[5:0]};
						rn = 2'd3;
					end
					mode_d  = MODE_NORMAL;
					hcnt_d  = 2'd0;
					hval_d  = '0;
					hstop_d = 1'b0;
				end else if (in_last) begin
					if (rb[0] == CH_BSLASH && rk > 2'd1) begin
						if (rb[1] != CH_U) begin
							r[rn] = map_escape(rb[1]);
							rn = rn + 2'd1;
						end
						if (rk == 2'd3) begin
							r[rn] = rb[2];
							rn = rn + 2'd1;
						end
					end else begin
						r[rn] = rb[0];
						rn = rn + 2'd1;
						if (rk > 2'd1) begin
							if (rb[1] == CH_BSLASH && rk > 2'd2) begin
								if (rb[2] != CH_U) begin
									r[rn] = map_escape(rb[2]);
									rn = rn + 2'd1;
								end
							end else begin
								r[rn] = rb[1];
								rn = rn + 2'd1;
								if (rk == 2'd3) begin
									r[rn] = rb[2];
									rn = rn + 2'd1;
								end
							end
						end
					end
				end else begin
					held_we = 1'b1;
					if (!hstop_q && hx.ok) begin
						hval_d = {hval_q[11:0], hx.digit};
					end else begin
						hstop_d = 1'b1;
					end
					hcnt_d = rk;
				end
			end
			default: begin
				if (in_byte == CH_BSLASH && !in_last) begin
					mode_d = MODE_BSLASH;
				end else begin
					r[rn] = in_byte;
					rn = rn + 2'd1;
				end
			end
		endcase
		if (in_last) begin
			mode_d  = MODE_NORMAL;
			hcnt_d  = 2'd0;
			hval_d  = '0;
			hstop_d = 1'b0;
			if (rn == 2'd0) begin
				r[0] = '0;
				rn   = 2'd1;
				rbv  = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			hcnt_q  <= 2'd0;
			hval_q  <= '0;
			hstop_q <= 1'b0;
			ocnt_q  <= 2'd0;
			olast_q <= 1'b0;
			obv_q   <= 1'b1;
		end else if (in_acc) begin
			mode_q  <= mode_d;
			hcnt_q  <= hcnt_d;
			hval_q  <= hval_d;
			hstop_q <= hstop_d;
			ocnt_q  <= rn;
			olast_q <= in_last;
			obv_q   <= rbv;
		end else if (out_acc) begin
			ocnt_q <= ocnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			obuf_q[0] <= r[0];
			obuf_q[1] <= r[1];
			obuf_q[2] <= r[2];
			if (held_we) begin
				held_q[hcnt_q] <= in_byte;
			end
		end else if (out_acc) begin
			obuf_q[0] <= obuf_q[1];
			obuf_q[1] <= obuf_q[2];
		end
	end

endmodule

>>> src/jsu_checker.sv
// Port-level checker for the JSON string unescaper and its bind
`include "json_string_unescape_top_macros.svh"

module jsu_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_stall,
	input jsu_pkg::byte_t in_byte,
	input logic          in_last,
	input logic          out_valid,
	input logic          out_stall,
	input jsu_pkg::byte_t out_byte,
	input logic          byte_valid,
	input logic          end_mark
);
	import jsu_pkg::*;

	`JSU_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_byte), "stalled output transaction changed")
	`JSU_ASSERT(a_marker_form, out_valid && !byte_valid |-> end_mark && out_byte == 8'h00, "empty end marker malformed")
	`JSU_ASSERT(a_empty_takes, !out_valid |-> !in_stall, "input stalled with an empty result buffer")
	`JSU_ASSERT(a_last_ends, in_valid && !in_stall && in_last |=> out_valid, "final byte produced no transaction")
	`JSU_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid, "output valid during reset")

endmodule

bind json_string_unescape_top jsu_checker u_jsu_checker (.*);

>>> sim/testbench.sv
// Testbench for the JSON string unescaper: directed table, then random strings, model-checked
module testbench;
	import jsu_pkg::*;

	typedef struct packed {
		byte_t data;
		logic  has_data;
		logic  end_flag;
	} out_rec_t;

	typedef struct packed {
		byte_t b;
		logic  last;
		logic  typed;
		logic  has;
		byte_t eb;
		logic  edv;
		logic  eem;
	} dir_row_t;

	logic  clk;
	logic  arst_n = 1'b0;
	logic  in_valid = 1'b0;
	logic  in_stall;
	byte_t in_byte = 8'h00;
	logic  in_last = 1'b0;
	logic  out_valid;
	logic  out_stall = 1'b0;
	byte_t out_byte;
	logic  byte_valid;
	logic  end_mark;

	json_string_unescape_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_byte    (in_byte),
		.in_last    (in_last),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.byte_valid (byte_valid),
		.end_mark   (end_mark)
	);

	logic [1:0]  esc_mode = MODE_NORMAL;
	logic [1:0]  hex_cnt = 2'd0;
	logic [15:0] hex_acc = 16'h0000;
	logic        hex_stop = 1'b0;
	byte_t       held [3];

	out_rec_t step_bytes [$];
	out_rec_t due_bytes [$];
	out_rec_t head;
	int          errors = 0;
	logic        quiet = 1'b0;

	dir_row_t dir_tab [0:24] = '{
		'{8'h00,     1'b0, 1'b1, 1'b1, 8'h00,     1'b1, 1'b0},
		'{8'hFF,     1'b1, 1'b1, 1'b1, 8'hFF,     1'b1, 1'b1},
		'{CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00,     1'b0, 1'b0},
		'{CH_N,      1'b0, 1'b1, 1'b1, CH_LF,     1'b1, 1'b0},
		'{CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00,     1'b0, 1'b0},
		'{8'h22,     1'b0, 1'b1, 1'b1, 8'h22,     1'b1, 1'b0},
		'{CH_BSLASH, 1'b1, 1'b1, 1'b1, CH_BSLASH, 1'b1, 1'b1},
		'{CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00,     1'b0, 1'b0},
		'{CH_U,      1'b1, 1'b1, 1'b1, 8'h00,     1'b0, 1'b1},
		'{CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00,     1'b0, 1'b0},
		'{CH_U,      1'b0, 1'b1, 1'b0, 8'h00,     1'b0, 1'b0},
		'{"F",       1'b0, 1'b0, 1'b0, 8'h00,     1'b0, 1'b0},
		'{"F",       1'b0, 1'b0, 1'b0, 8'h00,     1'b0, 1'b0},
		'{"f",       1'b0, 1'b0, 1'b0, 8'h00,     1'b0, 1'b0},
		'{"F",       1'b0, 1'b0, 1'b0, 8'h00,     1'b0, 1'b0},
		'{CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00,     1'b0, 1'b0},
		'{CH_U,      1'b0, 1'b1, 1'b0, 8'h00,     1'b0, 1'b0},
		'{"0",       1'b0, 1'b0, 1'b0, 8'h00,     1'b0, 1'b0},
		'{"g",       1'b0, 1'b0, 1'b0, 8'h00,     1'b0, 1'b0},
		'{"7",       1'b0, 1'b0, 1'b0, 8'h00,     1'b0, 1'b0},
		'{"A",       1'b0, 1'b0, 1'b0, 8'h00,     1'b0, 1'b0},
		'{CH_BSLASH, 1'b0, 1'b1, 1'b0, 8'h00,     1'b0, 1'b0},
		'{CH_U,      1'b0, 1'b1, 1'b0, 8'h00,     1'b0, 1'b0},
		'{CH_BSLASH, 1'b0, 1'b0, 1'b0, 8'h00,     1'b0, 1'b0},
		'{CH_N,      1'b1, 1'b0, 1'b0, 8'h00,     1'b0, 1'b0}
	};

	function automatic void add_rec(ref out_rec_t q [$], input out_rec_t e);
		q = {q, e};
	endfunction

	function automatic void add_char(ref byte_t q [$], input byte_t c);
		q = {q, c};
	endfunction

	function automatic void emit(input byte_t d);
		if (step_bytes.size() < 3) begin
			add_rec(step_bytes, '{d, 1'b1, 1'b0});
		end
	endfunction

	function automatic byte_t esc_char(input byte_t c);
		if (c == CH_N) return CH_LF;
		if (c == CH_R) return CH_CR;
		if (c == CH_T) return CH_TAB;
		return c;
	endfunction

	// {valid, value} of a hex digit
	function automatic logic [4:0] nibble_of(input byte_t c);
		if (c >= "0" && c <= "9") return {1'b1, 4'(c - "0")};
		if (c >= "a" && c <= "f") return {1'b1, 4'(c - "a" + 8'd10)};
		if (c >= "A" && c <= "F") return {1'b1, 4'(c - "A" + 8'd10)};
		return 5'd0;
	endfunction

	function automatic void emit_code_point(input logic [15:0] cp);
		if (cp < CP_ONE_LIMIT) begin
			emit(cp[7:0]);
		end else if (cp < CP_TWO_LIMIT) begin
			emit(LEAD_TWO | {3'd0, cp[10:6]});
			emit(CONT_MARK | {2'd0, cp[5:0]});
		end else begin
			emit(LEAD_THREE | {4'd0, cp[15:12]});
			emit(CONT_MARK | {2'd0, cp[11:6]});
			emit(CONT_MARK | {2'd0, cp[5:0]});
		end
	endfunction

	function automatic void clear_escape();
		esc_mode = MODE_NORMAL;
		hex_cnt = 2'd0;
		hex_acc = 16'h0000;
		hex_stop = 1'b0;
	endfunction

	// Compute the UTF-8 bytes caused by one raw byte into step_bytes
	function automatic void unescape_step(input byte_t b, input logic last);
		logic [4:0]  nib;
		logic [2:0]  k;
		logic [15:0] v;
		byte_t       tail [3];
		int          i;
		int          n;
		step_bytes.delete();
		nib = nibble_of(b);
		case (esc_mode)
			MODE_BSLASH: begin
				if (b == CH_U) begin
					clear_escape();
					esc_mode = MODE_UHEX;
				end else begin
					emit(esc_char(b));
					esc_mode = MODE_NORMAL;
				end
			end
			MODE_UHEX: begin
				k = {1'b0, hex_cnt} + 3'd1;
				if (k == 3'd4) begin
					v = hex_acc;
					if (!hex_stop && nib[4]) v = {hex_acc[11:0], nib[3:0]};
					emit_code_point(v);
					clear_escape();
				end else if (last) begin
					n = int'(k);
					for (i = 0; i < n - 1; i++) tail[i] = held[i];
					tail[n - 1] = b;
					i = 0;
					while (i < n) begin
						if (tail[i] == CH_BSLASH && i + 1 < n) begin
							i++;
							if (tail[i] != CH_U) emit(esc_char(tail[i]));
						end else begin
							emit(tail[i]);
						end
						i++;
					end
				end else begin
					held[k - 3'd1] = b;
					if (!hex_stop && nib[4]) hex_acc = {hex_acc[11:0], nib[3:0]};
					else hex_stop = 1'b1;
					hex_cnt = k[1:0];
				end
			end
			default: begin
				if (b == CH_BSLASH && !last) esc_mode = MODE_BSLASH;
				else emit(b);
			end
		endcase
		if (last) begin
			if (step_bytes.size() == 0) add_rec(step_bytes, '{8'h00, 1'b0, 1'b1});
			else step_bytes[step_bytes.size() - 1].end_flag = 1'b1;
			clear_escape();
		end
	endfunction

	task automatic send_byte(input byte_t b, input logic last);
		in_valid <= 1'b1;
		in_byte <= b;
		in_last <= last;
		do @(posedge clk); while (in_stall);
		unescape_step(b, last);
	endtask

	task automatic maybe_idle();
		if (!quiet && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (due_bytes.size() != 0);
	endtask

	function automatic byte_t hex_char(input logic [3:0] d);
		if (d < 4'd10) return 8'h30 + {4'd0, d};
		if ($urandom_range(0, 1) == 0) return "a" + {4'd0, d} - 8'd10;
		return "A" + {4'd0, d} - 8'd10;
	endfunction

	function automatic byte_t non_hex();
		byte_t c;
		do c = byte_t'($urandom_range(0, 255)); while (nibble_of(c) != 5'd0);
		return c;
	endfunction

	// Build one random string body into text
	function automatic void build_string(ref byte_t text [$]);
		int          tokens;
		int          t;
		int          j;
		int          cls;
		int          cut;
		logic [15:0] cp;
		byte_t       simple [7];
		simple = '{CH_N, CH_R, CH_T, 8'h22, CH_BSLASH, 8'h2F, 8'h00};
		text.delete();
		tokens = $urandom_range(1, 5);
		for (t = 0; t < tokens; t++) begin
			cls = $urandom_range(0, 9);
			if (cls <= 2) begin
				add_char(text, byte_t'($urandom_range(0, 255)));
			end else if (cls <= 4) begin
				simple[6] = byte_t'($urandom_range(0, 255));
				add_char(text, CH_BSLASH);
				add_char(text, simple[$urandom_range(0, 6)]);
			end else if (cls <= 8) begin
				case ($urandom_range(0, 2))
					0: cp = 16'($urandom_range(0, 16'h007F));
					1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
					default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
				endcase
				cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : 4;
				add_char(text, CH_BSLASH);
				add_char(text, CH_U);
				for (j = 3; j >= 0; j--) begin
					if (3 - j == cut) add_char(text, non_hex());
					else add_char(text, hex_char(cp[4 * j +: 4]));
				end
			end else begin
				add_char(text, CH_BSLASH);
				add_char(text, CH_U);
				cut = $urandom_range(1, 3);
				for (j = 0; j < cut; j++) begin
					case ($urandom_range(0, 4))
						0: add_char(text, CH_BSLASH);
						1: add_char(text, CH_U);
						2: add_char(text, CH_N);
						3: add_char(text, byte_t'($urandom_range(0, 255)));
						default: add_char(text, hex_char(4'($urandom_range(0, 15))));
					endcase
				end
				return;
			end
		end
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		forever begin
			repeat ($urandom_range(1, 20)) @(posedge clk);
			if (!quiet) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (due_bytes.size() == 0) begin
				$error("unexpected transaction: out_byte %h byte_valid %b end_mark %b",
					out_byte, byte_valid, end_mark);
				errors++;
			end else begin
				head = due_bytes.pop_front();
				if (out_byte !== head.data) begin
					$error("out_byte: expected %h, got %h", head.data, out_byte);
					errors++;
				end
				if (byte_valid !== head.has_data) begin
					$error("byte_valid: expected %b, got %b", head.has_data, byte_valid);
					errors++;
				end
				if (end_mark !== head.end_flag) begin
					$error("end_mark: expected %b, got %b", head.end_flag, end_mark);
					errors++;
				end
			end
		end
	end

	initial begin
		#3000000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		byte_t text [$];
		int    sent;
		int    r;
		int    i;
		logic  drained;
		sent = 0;
		drained = 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (r = 0; r < 25; r++) begin
			send_byte(dir_tab[r].b, dir_tab[r].last);
			if (!dir_tab[r].typed) begin
				foreach (step_bytes[i]) add_rec(due_bytes, step_bytes[i]);
			end else if (dir_tab[r].has) begin
				add_rec(due_bytes, '{dir_tab[r].eb, dir_tab[r].edv, dir_tab[r].eem});
			end
			maybe_idle();
		end
		drain();
		while (sent < 195) begin
			quiet = (sent >= 160);
			build_string(text);
			for (i = 0; i < text.size(); i++) begin
				send_byte(text[i], i == text.size() - 1);
				foreach (step_bytes[r]) add_rec(due_bytes, step_bytes[r]);
				maybe_idle();
			end
			sent += text.size();
			if (!drained && sent >= 100) begin
				drain();
				drained = 1'b1;
			end
		end
		drain();
		repeat (8) @(posedge clk);
		if (errors == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end

endmodule
